FILE: sv/mrl_pkg.sv
// Shared types, constants and helpers for the motor R/L identifier.
`timescale 1ns / 1ps
package mrl_pkg;

    // Field and storage widths
    localparam int VOLT_W     = 24;
    localparam int CUR_W      = 16;
    localparam int WAIT_W     = 17;
    localparam int SUM_W      = 34;
    localparam int LSUM_W     = 40;
    localparam int STAGE_W    = 4;
    localparam int REP_W      = 8;
    localparam int DIV_NUM_W  = 54;
    localparam int DIV_DEN_W  = 17;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_AW     = 5;
    localparam int CFG_DW     = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 80;

    // Reciprocal of 1000 at scale 2^64, rounded up; exact for dividends below 2^54
    localparam int RCP_W      = 55;
    localparam int RCP_ACC_W  = 109;
    localparam int RCP_SHIFT  = 64;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
    localparam logic [REP_W-1:0]  REP_MAX  = '1;
    localparam logic [LSUM_W-1:0] LSUM_MAX = '1;
    localparam logic [VOLT_W-1:0] VOLT_MAX = '1;
    localparam logic [RCP_W-1:0]  NS_RECIP = 55'd18446744073709552;
    localparam logic [8:0] IND_SCALE = 9'd334;

    // Measurement stages
    localparam logic [STAGE_W-1:0] STG_CLEAR      = 4'd0;
    localparam logic [STAGE_W-1:0] STG_RAMP_LOW   = 4'd1;
    localparam logic [STAGE_W-1:0] STG_AVG_LOW    = 4'd2;
    localparam logic [STAGE_W-1:0] STG_RAMP_FULL  = 4'd3;
    localparam logic [STAGE_W-1:0] STG_AVG_FULL   = 4'd4;
    localparam logic [STAGE_W-1:0] STG_RESIST     = 4'd5;
    localparam logic [STAGE_W-1:0] STG_WAIT_ZERO  = 4'd6;
    localparam logic [STAGE_W-1:0] STG_STEP_RESP  = 4'd7;
    localparam logic [STAGE_W-1:0] STG_IND_RESULT = 4'd8;

    // Register indexes
    localparam logic [2:0] REG_CURRENT_LIMIT = 3'd0;
    localparam logic [2:0] REG_VOLTAGE_STEP  = 3'd1;
    localparam logic [2:0] REG_SETTLE_TICKS  = 3'd2;
    localparam logic [2:0] REG_AVERAGE_COUNT = 3'd3;
    localparam logic [2:0] REG_TICK_NS       = 3'd4;
    localparam logic [2:0] REG_ZERO_BAND     = 3'd5;

    typedef struct packed {
        logic [14:0] current_limit;
        logic [7:0]  voltage_step;
        logic [15:0] settle_ticks;
        logic [7:0]  average_count;
        logic [19:0] tick_nanoseconds;
        logic [11:0] zero_band;
    } t_cfg;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LATCH, CMD_INIT, CMD_RAMP_MUL, CMD_RAMP_EVAL,
        CMD_SETTLE_UPD, CMD_AVG_START, CMD_AVG_STORE, CMD_RES_START, CMD_RES_STORE,
        CMD_ZERO, CMD_STEP_UPD, CMD_IND_MUL1, CMD_IND_MUL2, CMD_IND_MUL3,
        CMD_IND_MUL4, CMD_IND_MUL5, CMD_IND_DIV, CMD_IND_ACC, CMD_L_START,
        CMD_L_STORE, CMD_OUT_LOAD
    } t_cmd;

    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic ramp_pass;
        logic settle_close;
        logic in_band;
        logic step_hit;
        logic rep_reach;
        logic div_done;
    } t_sts;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_INIT, ST_RAMP_MUL, ST_RAMP_EVAL,
        ST_SETTLE_UPD, ST_SETTLE_CHK, ST_AVG_START, ST_AVG_WAIT, ST_AVG_STORE,
        ST_RES_START, ST_RES_WAIT, ST_RES_STORE, ST_ZERO, ST_STEP_UPD,
        ST_STEP_CHK, ST_IND_MUL1, ST_IND_MUL2, ST_IND_MUL3, ST_IND_MUL4,
        ST_IND_MUL5, ST_IND_DIV, ST_IND_WAIT, ST_IND_ACC, ST_L_START,
        ST_L_WAIT, ST_L_STORE, ST_FINISH
    } t_ctl_state;

    // A zero average count acts as one
    function automatic logic [7:0] avg_n(input logic [7:0] cnt);
        avg_n = (cnt == 8'd0) ? 8'd1 : cnt;
    endfunction

endpackage

FILE: sv/mrl_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mrl_div import mrl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_dividend,
    input  logic [DIV_DEN_W-1:0] i_divisor,
    output logic                 o_busy,
    output logic [DIV_NUM_W-1:0] o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_dsr;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W:0]   w_trial;
    logic                 w_ge;
    logic [DIV_DEN_W:0]   w_diff;

    // Shift in one dividend bit and try the subtraction
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_NUM_W-1]};
        w_ge    = w_trial >= {1'b0, r_dsr};
        w_diff  = w_trial - {1'b0, r_dsr};
    end

    // Control: count the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: sv/mrl_cfg.sv
// APB register file for the identifier settings.
`timescale 1ns / 1ps
module mrl_cfg import mrl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[CFG_AW-1:2];

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_limit    <= 15'd2458;
            r_cfg.voltage_step     <= 8'd7;
            r_cfg.settle_ticks     <= 16'd4000;
            r_cfg.average_count    <= 8'd100;
            r_cfg.tick_nanoseconds <= 20'd50000;
            r_cfg.zero_band        <= 12'd205;
        end else if (w_wr) begin
            case (w_idx)
                REG_CURRENT_LIMIT: r_cfg.current_limit    <= pwdata[14:0];
                REG_VOLTAGE_STEP:  r_cfg.voltage_step     <= pwdata[7:0];
                REG_SETTLE_TICKS:  r_cfg.settle_ticks     <= pwdata[15:0];
                REG_AVERAGE_COUNT: r_cfg.average_count    <= pwdata[7:0];
                REG_TICK_NS:       r_cfg.tick_nanoseconds <= pwdata[19:0];
                REG_ZERO_BAND:     r_cfg.zero_band        <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_CURRENT_LIMIT: prdata = {17'd0, r_cfg.current_limit};
            REG_VOLTAGE_STEP:  prdata = {24'd0, r_cfg.voltage_step};
            REG_SETTLE_TICKS:  prdata = {16'd0, r_cfg.settle_ticks};
            REG_AVERAGE_COUNT: prdata = {24'd0, r_cfg.average_count};
            REG_TICK_NS:       prdata = {12'd0, r_cfg.tick_nanoseconds};
            REG_ZERO_BAND:     prdata = {20'd0, r_cfg.zero_band};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/mrl_ctrl.sv
// Sequencer that walks one tick through the measurement stages.
`timescale 1ns / 1ps
module mrl_ctrl import mrl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_ctl_state r_state, n_state;
    logic       r_ovalid, n_ovalid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (i_in_valid) n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                case (i_sts.stage)
                    STG_RAMP_LOW, STG_RAMP_FULL: n_state = ST_RAMP_MUL;
                    STG_AVG_LOW, STG_AVG_FULL:   n_state = ST_SETTLE_UPD;
                    STG_RESIST:                  n_state = ST_RES_START;
                    STG_WAIT_ZERO:               n_state = ST_ZERO;
                    STG_STEP_RESP:               n_state = ST_STEP_UPD;
                    STG_IND_RESULT:              n_state = ST_L_START;
                    default:                     n_state = ST_INIT;
                endcase
            end
            ST_INIT:       n_state = ST_RAMP_MUL;
            ST_RAMP_MUL:   n_state = ST_RAMP_EVAL;
            ST_RAMP_EVAL:  n_state = i_sts.ramp_pass ? ST_DISPATCH : ST_FINISH;
            ST_SETTLE_UPD: n_state = ST_SETTLE_CHK;
            ST_SETTLE_CHK: n_state = i_sts.settle_close ? ST_AVG_START : ST_FINISH;
            ST_AVG_START:  n_state = ST_AVG_WAIT;
            ST_AVG_WAIT:   if (i_sts.div_done) n_state = ST_AVG_STORE;
            ST_AVG_STORE:  n_state = ST_DISPATCH;
            ST_RES_START:  n_state = ST_RES_WAIT;
            ST_RES_WAIT:   if (i_sts.div_done) n_state = ST_RES_STORE;
            ST_RES_STORE:  n_state = ST_FINISH;
            ST_ZERO:       n_state = i_sts.in_band ? ST_STEP_UPD : ST_FINISH;
            ST_STEP_UPD:   n_state = ST_STEP_CHK;
            ST_STEP_CHK:   n_state = i_sts.step_hit ? ST_IND_MUL1 : ST_FINISH;
            ST_IND_MUL1:   n_state = ST_IND_MUL2;
            ST_IND_MUL2:   n_state = ST_IND_MUL3;
            ST_IND_MUL3:   n_state = ST_IND_MUL4;
            ST_IND_MUL4:   n_state = ST_IND_MUL5;
            ST_IND_MUL5:   n_state = ST_IND_DIV;
            ST_IND_DIV:    n_state = ST_IND_WAIT;
            ST_IND_WAIT:   if (i_sts.div_done) n_state = ST_IND_ACC;
            ST_IND_ACC:    n_state = i_sts.rep_reach ? ST_L_START : ST_FINISH;
            ST_L_START:    n_state = ST_L_WAIT;
            ST_L_WAIT:     if (i_sts.div_done) n_state = ST_L_STORE;
            ST_L_STORE:    n_state = ST_FINISH;
            ST_FINISH:     if (!r_ovalid || i_out_ready) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // Outputs: command to the datapath and handshakes
    always_comb begin
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        n_ovalid   = (r_ovalid && i_out_ready) ? 1'b0 : r_ovalid;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = CMD_LATCH;
            end
            ST_INIT:       o_cmd = CMD_INIT;
            ST_RAMP_MUL:   o_cmd = CMD_RAMP_MUL;
            ST_RAMP_EVAL:  o_cmd = CMD_RAMP_EVAL;
            ST_SETTLE_UPD: o_cmd = CMD_SETTLE_UPD;
            ST_AVG_START:  o_cmd = CMD_AVG_START;
            ST_AVG_STORE:  o_cmd = CMD_AVG_STORE;
            ST_RES_START:  o_cmd = CMD_RES_START;
            ST_RES_STORE:  o_cmd = CMD_RES_STORE;
            ST_ZERO:       o_cmd = CMD_ZERO;
            ST_STEP_UPD:   o_cmd = CMD_STEP_UPD;
            ST_IND_MUL1:   o_cmd = CMD_IND_MUL1;
            ST_IND_MUL2:   o_cmd = CMD_IND_MUL2;
            ST_IND_MUL3:   o_cmd = CMD_IND_MUL3;
            ST_IND_MUL4:   o_cmd = CMD_IND_MUL4;
            ST_IND_MUL5:   o_cmd = CMD_IND_MUL5;
            ST_IND_DIV:    o_cmd = CMD_IND_DIV;
            ST_IND_ACC:    o_cmd = CMD_IND_ACC;
            ST_L_START:    o_cmd = CMD_L_START;
            ST_L_STORE:    o_cmd = CMD_L_STORE;
            ST_FINISH: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd    = CMD_OUT_LOAD;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

FILE: sv/mrl_dp.sv
// Datapath: measurement state, multipliers, divider and result register.
`timescale 1ns / 1ps
module mrl_dp import mrl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_cfg                  i_cfg,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    output t_sts                  o_sts,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    // Measurement state
    logic signed [CUR_W-1:0] r_cur;
    logic [VOLT_W-1:0]       r_bus;
    logic [STAGE_W-1:0]      r_stage;
    logic [VOLT_W-1:0]       r_drive;
    logic [WAIT_W-1:0]       r_wait;
    logic signed [SUM_W-1:0] r_sum;
    logic [VOLT_W-1:0]       r_sv0, r_sv1;
    logic signed [CUR_W-1:0] r_sc0, r_sc1;
    logic [VOLT_W-1:0]       r_res;
    logic [LSUM_W-1:0]       r_lsum;
    logic [REP_W-1:0]        r_rep;
    logic                    r_done;
    logic [VOLT_W-1:0]       r_lval;
    // Product registers
    logic signed [40:0]      r_pcd;
    logic [38:0]             r_plb;
    logic [43:0]             r_p1;
    logic [38:0]             r_plo;
    logic [38:0]             r_phi;
    logic [44:0]             r_a;
    logic [DIV_NUM_W-1:0]    r_b;
    logic [OUT_DATA_W-1:0]   r_odata;
    // Divide by 1000 through the reciprocal
    logic                    r_kbusy;
    logic [1:0]              r_kstep;
    logic [RCP_ACC_W-1:0]    r_kacc;

    logic [7:0]              w_n;
    logic                    w_idx;
    logic signed [45:0]      w_pcd_ext, w_lhs, w_rhs;
    logic [VOLT_W:0]         w_drive_sum;
    logic [VOLT_W-1:0]       w_drive_ramp;
    logic [WAIT_W-1:0]       w_wait_inc;
    logic [WAIT_W-1:0]       w_close_lim;
    logic [SUM_W-1:0]        w_sum_mag;
    logic signed [VOLT_W:0]  w_dv;
    logic signed [CUR_W:0]   w_di;
    logic [VOLT_W:0]         w_mv;
    logic [CUR_W:0]          w_mi;
    logic signed [CUR_W:0]   w_cur17, w_zb17;
    logic signed [21:0]      w_c22, w_s22, w_c20, w_s19;
    logic [REP_W-1:0]        w_rep_inc;
    logic [45:0]             w_lsum_add;
    logic [60:0]             w_full;
    logic [CUR_W-1:0]        w_avg;
    logic [VOLT_W-1:0]       w_res_val;
    logic                    w_div_start;
    logic [DIV_NUM_W-1:0]    w_dividend;
    logic [DIV_DEN_W-1:0]    w_divisor;
    logic                    w_div_busy;
    logic [DIV_NUM_W-1:0]    w_quo;
    logic [26:0]             w_ka;
    logic [27:0]             w_kb;
    logic [RCP_W-1:0]        w_kprod;
    logic [RCP_ACC_W-1:0]    w_kterm;

    // Shared divider
    mrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // Derived values and tests
    always_comb begin
        w_n   = avg_n(i_cfg.average_count);
        w_idx = (r_stage == STG_RAMP_FULL) || (r_stage == STG_AVG_FULL);

        // Ramp target test, cross-multiplied
        w_pcd_ext = {{5{r_pcd[40]}}, r_pcd};
        w_lhs = (r_stage == STG_RAMP_LOW) ? (w_pcd_ext <<< 2) + w_pcd_ext
                                          : (w_pcd_ext <<< 1) + w_pcd_ext;
        w_rhs = $signed({6'd0, r_plb, 1'b0});

        w_drive_sum  = {1'b0, r_drive} + {17'd0, i_cfg.voltage_step};
        w_drive_ramp = w_drive_sum[VOLT_W] ? VOLT_MAX : w_drive_sum[VOLT_W-1:0];

        w_wait_inc  = (r_wait == WAIT_MAX) ? r_wait : r_wait + 1'b1;
        w_close_lim = {1'b0, i_cfg.settle_ticks} + {9'd0, w_n};

        w_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

        // Rounded average, clamped to the current range
        if (!r_sum[SUM_W-1]) begin
            w_avg = (w_quo > DIV_NUM_W'(32767)) ? 16'h7FFF : w_quo[CUR_W-1:0];
        end else begin
            w_avg = (w_quo > DIV_NUM_W'(32768)) ? 16'h8000 : CUR_W'(-w_quo[CUR_W-1:0]);
        end

        // Two-point differences for resistance
        w_dv = $signed({1'b0, r_sv1}) - $signed({1'b0, r_sv0});
        w_di = $signed({r_sc1[CUR_W-1], r_sc1}) - $signed({r_sc0[CUR_W-1], r_sc0});
        w_mv = w_dv[VOLT_W] ? (VOLT_W+1)'(-w_dv) : (VOLT_W+1)'(w_dv);
        w_mi = w_di[CUR_W] ? (CUR_W+1)'(-w_di) : (CUR_W+1)'(w_di);
        if (w_dv == '0) begin
            w_res_val = '0;
        end else if (w_di == '0) begin
            w_res_val = VOLT_MAX;
        end else if (w_dv[VOLT_W] != w_di[CUR_W]) begin
            w_res_val = '0;
        end else begin
            w_res_val = (w_quo > DIV_NUM_W'(VOLT_MAX)) ? VOLT_MAX : w_quo[VOLT_W-1:0];
        end

        // Zero band and step response tests
        w_cur17 = {r_cur[CUR_W-1], r_cur};
        w_zb17  = $signed({5'd0, i_cfg.zero_band});
        w_c22   = {{6{r_cur[CUR_W-1]}}, r_cur};
        w_s22   = {{6{r_sc1[CUR_W-1]}}, r_sc1};
        w_c20   = (w_c22 <<< 4) + (w_c22 <<< 2);
        w_s19   = (w_s22 <<< 4) + (w_s22 <<< 1) + w_s22;

        w_rep_inc  = (r_rep == REP_MAX) ? r_rep : r_rep + 1'b1;
        w_lsum_add = {6'd0, r_lsum} + {1'd0, r_kacc[RCP_ACC_W-1:RCP_SHIFT]};
        w_full     = {r_phi, 22'd0} + {22'd0, r_plo};
    end

    // Reciprocal partial product: dividend and reciprocal split in halves
    always_comb begin
        w_ka = r_b[26:0];
        w_kb = NS_RECIP[27:0];
        case (r_kstep)
            2'd1: w_kb = {1'b0, NS_RECIP[54:28]};
            2'd2: w_ka = r_b[53:27];
            2'd3: begin
                w_ka = r_b[53:27];
                w_kb = {1'b0, NS_RECIP[54:28]};
            end
            default: begin
            end
        endcase
        w_kprod = {28'd0, w_ka} * {27'd0, w_kb};
        case (r_kstep)
            2'd1:    w_kterm = {26'd0, w_kprod, 28'd0};
            2'd2:    w_kterm = {27'd0, w_kprod, 27'd0};
            2'd3:    w_kterm = {w_kprod[53:0], 55'd0};
            default: w_kterm = {54'd0, w_kprod};
        endcase
    end

    // Reciprocal sequencing: four partial products, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbusy <= 1'b0;
            r_kstep <= '0;
        end else if (i_cmd == CMD_IND_DIV) begin
            r_kbusy <= 1'b1;
            r_kstep <= '0;
        end else if (r_kbusy) begin
            r_kstep <= r_kstep + 1'b1;
            if (r_kstep == 2'd3) begin
                r_kbusy <= 1'b0;
            end
        end
    end

    // Accumulate the partial products
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_IND_DIV) begin
            r_kacc <= '0;
        end else if (r_kbusy) begin
            r_kacc <= r_kacc + w_kterm;
        end
    end

    // Divider operand selection
    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = {20'd0, w_sum_mag} + DIV_NUM_W'(w_n[7:1]);
        w_divisor   = {9'd0, w_n};
        case (i_cmd)
            CMD_AVG_START: w_div_start = 1'b1;
            CMD_RES_START: begin
                w_div_start = 1'b1;
                w_dividend  = {17'd0, w_mv, 12'd0};
                w_divisor   = w_mi;
            end
            CMD_L_START: begin
                w_div_start = 1'b1;
                w_dividend  = {14'd0, r_lsum};
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= STG_CLEAR;
            r_drive <= '0;
            r_wait  <= '0;
            r_sum   <= '0;
            r_sv0   <= '0;
            r_sv1   <= '0;
            r_sc0   <= '0;
            r_sc1   <= '0;
            r_res   <= '0;
            r_lsum  <= '0;
            r_rep   <= '0;
            r_done  <= 1'b0;
            r_lval  <= '0;
        end else begin
            case (i_cmd)
                CMD_INIT: begin
                    r_drive <= '0;
                    r_rep   <= '0;
                    r_wait  <= '0;
                    r_stage <= STG_RAMP_LOW;
                end
                CMD_RAMP_EVAL: begin
                    if (w_lhs >= w_rhs) begin
                        r_stage <= r_stage + 1'b1;
                    end else begin
                        r_drive <= w_drive_ramp;
                        if (w_idx) r_sv1 <= w_drive_ramp;
                        else       r_sv0 <= w_drive_ramp;
                    end
                end
                CMD_SETTLE_UPD: begin
                    r_wait <= w_wait_inc;
                    if (w_wait_inc > {1'b0, i_cfg.settle_ticks}) begin
                        r_sum <= r_sum + {{(SUM_W-CUR_W){r_cur[CUR_W-1]}}, r_cur};
                    end
                end
                CMD_AVG_STORE: begin
                    if (w_idx) r_sc1 <= w_avg;
                    else       r_sc0 <= w_avg;
                    r_wait  <= '0;
                    r_sum   <= '0;
                    r_stage <= r_stage + 1'b1;
                end
                CMD_RES_STORE: begin
                    r_res   <= w_res_val;
                    r_drive <= '0;
                    r_stage <= STG_WAIT_ZERO;
                end
                CMD_ZERO: begin
                    r_drive <= '0;
                    if ((w_cur17 >= -w_zb17) && (w_cur17 <= w_zb17)) begin
                        r_stage <= STG_STEP_RESP;
                    end
                end
                CMD_STEP_UPD: begin
                    r_drive <= r_sv1;
                    r_wait  <= w_wait_inc;
                end
                CMD_IND_ACC: begin
                    r_lsum  <= (w_lsum_add > {6'd0, LSUM_MAX}) ? LSUM_MAX
                                                               : w_lsum_add[LSUM_W-1:0];
                    r_wait  <= '0;
                    r_rep   <= w_rep_inc;
                    r_drive <= '0;
                    r_stage <= (w_rep_inc >= w_n) ? STG_IND_RESULT : STG_WAIT_ZERO;
                end
                CMD_L_STORE: begin
                    r_lval  <= (w_quo > DIV_NUM_W'(VOLT_MAX)) ? VOLT_MAX
                                                              : w_quo[VOLT_W-1:0];
                    r_lsum  <= '0;
                    r_wait  <= '0;
                    r_stage <= STG_CLEAR;
                    r_done  <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Input word, products and result word
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LATCH: begin
                r_cur <= i_in_data[CUR_W-1:0];
                r_bus <= i_in_data[CUR_W+VOLT_W-1:CUR_W];
            end
            CMD_RAMP_MUL: begin
                r_pcd <= $signed({{25{r_cur[CUR_W-1]}}, r_cur}) * $signed({17'd0, r_drive});
                r_plb <= {24'd0, i_cfg.current_limit} * {15'd0, r_bus};
            end
            CMD_IND_MUL1: r_p1  <= {20'd0, r_res} * {24'd0, i_cfg.tick_nanoseconds};
            CMD_IND_MUL2: r_plo <= {17'd0, r_p1[21:0]} * {22'd0, r_wait};
            CMD_IND_MUL3: r_phi <= {17'd0, r_p1[43:22]} * {22'd0, r_wait};
            CMD_IND_MUL4: r_a   <= w_full[60:16];
            CMD_IND_MUL5: r_b   <= {9'd0, r_a} * {45'd0, IND_SCALE};
            CMD_OUT_LOAD: r_odata <= {3'd0, r_done, r_lval, r_res, r_stage, r_drive};
            default: begin
            end
        endcase
    end

    // Status back to the sequencer
    always_comb begin
        o_sts.stage        = r_stage;
        o_sts.ramp_pass    = w_lhs >= w_rhs;
        o_sts.settle_close = r_wait >= w_close_lim;
        o_sts.in_band      = (w_cur17 >= -w_zb17) && (w_cur17 <= w_zb17);
        o_sts.step_hit     = w_c20 >= w_s19;
        o_sts.rep_reach    = w_rep_inc >= w_n;
        o_sts.div_done     = !w_div_busy && !r_kbusy;
    end

    assign o_out_data = r_odata;

endmodule

FILE: sv/motor_rl_identifier_core.sv
// Top level of the motor resistance and inductance identifier.
// Each word walks the stages run in its tick and finishes once the result side has room;
// each average, resistance or inductance division holds the shared serial divider,
// and the divide by 1000 runs on the reciprocal multiplier.
// One word is in flight; the next is taken in the idle cycle after the result is loaded.
// Reset: i_rst_n synchronous active low; settings return to defaults, stage to clear.
`timescale 1ns / 1ps
module motor_rl_identifier_core import mrl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB settings port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_AW-1:0]     paddr,
    input  logic [CFG_DW-1:0]     pwdata,
    output logic [CFG_DW-1:0]     prdata,
    output logic                  pready,
    // Sample stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] phase_current, [39:16] bus_voltage
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [23:0] drive_voltage, [27:24] stage, [51:28] resistance,
    // [75:52] inductance, [76] finished, [79:77] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cfg w_cfg;
    t_sts w_sts;
    t_cmd w_cmd;

    mrl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    mrl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg      (w_cfg),
        .i_in_data  (s_axis_tdata),
        .o_sts      (w_sts),
        .o_out_data (m_axis_tdata)
    );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for the motor R/L identifier: sample stream in, result stream out.
`timescale 1ns / 1ps
module testbench;
    import mrl_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_AW-1:0]     paddr;
    logic [CFG_DW-1:0]     pwdata;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [15:0] phase_current, [39:16] bus_voltage
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [23:0] drive_voltage, [27:24] stage, [51:28] resistance,
    // [75:52] inductance, [76] finished, [79:77] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    motor_rl_identifier_core dut (.*);

    // Pending samples, expected result words, bench control
    logic [IN_DATA_W-1:0]  sample_q[$];
    logic [OUT_DATA_W-1:0] result_q[$];
    int                    err_count;
    int                    cycle_count;
    int                    send_idle_pct;
    int                    recv_stall_pct;

    // Mirror of the settings registers
    t_cfg cfg;

    // Mirror of the measurement state
    logic [3:0]  m_stage;
    longint      m_drive;
    longint      m_wait;
    longint      m_csum;
    longint      m_stepv[2];
    longint      m_stepi[2];
    longint      m_res;
    longint unsigned m_lsum;
    longint      m_rep;
    logic        m_done;
    longint      m_ind;

    function automatic longint eff_avg();
        return (cfg.average_count == 0) ? 1 : longint'(cfg.average_count);
    endfunction

    function automatic void ramp_drive(int idx);
        if (m_drive + cfg.voltage_step > 64'hFFFFFF) m_drive = 64'hFFFFFF;
        else m_drive += cfg.voltage_step;
        m_stepv[idx] = m_drive;
    endfunction

    function automatic longint round_mean(longint sum, longint n);
        longint mag;
        longint q;
        mag = (sum < 0) ? -sum : sum;
        q = (mag + n / 2) / n;
        if (sum < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    // Settle, then accumulate; return 1 when the averaging window closes
    function automatic bit window_close(longint cur, int idx);
        longint n;
        n = eff_avg();
        if (m_wait < 131071) m_wait++;
        if (m_wait > cfg.settle_ticks) m_csum += cur;
        if (m_wait >= cfg.settle_ticks + n) begin
            m_stepi[idx] = round_mean(m_csum, n);
            m_wait = 0;
            m_csum = 0;
            return 1;
        end
        return 0;
    endfunction

    function automatic longint two_point_resistance();
        longint dv;
        longint di;
        longint q;
        dv = m_stepv[1] - m_stepv[0];
        di = m_stepi[1] - m_stepi[0];
        if (dv == 0) return 0;
        if (di == 0) return 64'hFFFFFF;
        if ((dv < 0) != (di < 0)) return 0;
        if (dv < 0) dv = -dv;
        if (di < 0) di = -di;
        q = (dv <<< 12) / di;
        return (q > 64'hFFFFFF) ? 64'hFFFFFF : q;
    endfunction

    // Advance the mirror by one control tick and return the expected word
    function automatic logic [OUT_DATA_W-1:0] identify_tick(logic [IN_DATA_W-1:0] word);
        longint cur;
        longint bus;
        longint lim2;
        longint unsigned a;
        longint unsigned inc;
        longint unsigned l;
        cur = longint'($signed(word[15:0]));
        bus = longint'(word[39:16]);
        lim2 = 2 * longint'(cfg.current_limit) * bus;
        if (m_stage > STG_IND_RESULT) m_stage = STG_CLEAR;
        if (m_stage <= STG_RESIST) begin
            if (m_stage == STG_CLEAR) begin
                m_drive = 0; m_rep = 0; m_wait = 0;
                m_stage = STG_RAMP_LOW;
            end
            if (m_stage == STG_RAMP_LOW) begin
                if (5 * cur * m_drive >= lim2) m_stage = STG_AVG_LOW;
                else ramp_drive(0);
            end
            if (m_stage == STG_AVG_LOW && window_close(cur, 0)) m_stage = STG_RAMP_FULL;
            if (m_stage == STG_RAMP_FULL) begin
                if (3 * cur * m_drive >= lim2) m_stage = STG_AVG_FULL;
                else ramp_drive(1);
            end
            if (m_stage == STG_AVG_FULL && window_close(cur, 1)) m_stage = STG_RESIST;
            if (m_stage == STG_RESIST) begin
                m_res = two_point_resistance();
                m_drive = 0;
                m_stage = STG_WAIT_ZERO;
            end
        end else begin
            if (m_stage == STG_WAIT_ZERO) begin
                m_drive = 0;
                if (cur >= -longint'(cfg.zero_band) && cur <= longint'(cfg.zero_band))
                    m_stage = STG_STEP_RESP;
            end
            if (m_stage == STG_STEP_RESP) begin
                m_drive = m_stepv[1];
                if (m_wait < 131071) m_wait++;
                if (20 * cur >= 19 * m_stepi[1]) begin
                    a = (longint'(m_res) * longint'(cfg.tick_nanoseconds) * m_wait) >> 16;
                    inc = a * 334 / 1000;
                    if (inc > 64'hFF_FFFF_FFFF - m_lsum) m_lsum = 64'hFF_FFFF_FFFF;
                    else m_lsum += inc;
                    m_wait = 0;
                    if (m_rep < 255) m_rep++;
                    m_stage = STG_WAIT_ZERO;
                    m_drive = 0;
                    if (m_rep >= eff_avg()) m_stage = STG_IND_RESULT;
                end
            end
            if (m_stage == STG_IND_RESULT) begin
                l = m_lsum / eff_avg();
                m_ind = (l > 64'hFFFFFF) ? 64'hFFFFFF : l;
                m_lsum = 0;
                m_wait = 0;
                m_stage = STG_CLEAR;
                m_done = 1'b1;
            end
        end
        return {3'b000, m_done, m_ind[23:0], m_res[23:0], m_stage, m_drive[23:0]};
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sample driver: hold the word until taken, idle at random between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(identify_tick(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tdata  <= sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted word field by field
    always @(posedge i_clk) begin
        logic [OUT_DATA_W-1:0] exp_word;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_q.size() == 0) begin
                    $display("%t unexpected word %h", $time, m_axis_tdata);
                    err_count++;
                end else begin
                    exp_word = result_q.pop_front();
                    if (m_axis_tdata[23:0] !== exp_word[23:0])
                        $display("%t drive_voltage exp %h act %h", $time,
                                 exp_word[23:0], m_axis_tdata[23:0]);
                    if (m_axis_tdata[27:24] !== exp_word[27:24])
                        $display("%t stage exp %h act %h", $time,
                                 exp_word[27:24], m_axis_tdata[27:24]);
                    if (m_axis_tdata[51:28] !== exp_word[51:28])
                        $display("%t resistance exp %h act %h", $time,
                                 exp_word[51:28], m_axis_tdata[51:28]);
                    if (m_axis_tdata[75:52] !== exp_word[75:52])
                        $display("%t inductance exp %h act %h", $time,
                                 exp_word[75:52], m_axis_tdata[75:52]);
                    if (m_axis_tdata[79:76] !== exp_word[79:76])
                        $display("%t finished exp %h act %h", $time,
                                 exp_word[79:76], m_axis_tdata[79:76]);
                    if (m_axis_tdata !== exp_word) err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %t", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One register write: setup then access
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CFG_AW'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CURRENT_LIMIT: cfg.current_limit    = value[14:0];
            REG_VOLTAGE_STEP:  cfg.voltage_step     = value[7:0];
            REG_SETTLE_TICKS:  cfg.settle_ticks     = value[15:0];
            REG_AVERAGE_COUNT: cfg.average_count    = value[7:0];
            REG_TICK_NS:       cfg.tick_nanoseconds = value[19:0];
            REG_ZERO_BAND:     cfg.zero_band        = value[11:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(int lim, int vstep, int settle, int avg, int tns, int zb);
        reg_write(REG_CURRENT_LIMIT, lim);
        reg_write(REG_VOLTAGE_STEP, vstep);
        reg_write(REG_SETTLE_TICKS, settle);
        reg_write(REG_AVERAGE_COUNT, avg);
        reg_write(REG_TICK_NS, tns);
        reg_write(REG_ZERO_BAND, zb);
    endtask

    // Wait until every queued word is sent and every result is back
    task automatic drain();
        while (sample_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random tick biased toward moving the measurement along
    task automatic queue_random(int count);
        int pick;
        logic [15:0] cur;
        logic [23:0] bus;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 35)      cur = 16'($urandom_range(32767, 8192));
            else if (pick < 60) cur = 16'($urandom_range(400) - 200);
            else if (pick < 80) cur = 16'($urandom_range(8192));
            else                cur = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 40)      bus = '0;
            else if (pick < 70) bus = 24'($urandom_range(4096));
            else                bus = 24'($urandom);
            sample_q.push_back({bus, cur});
        end
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
    endtask

    // Stimulus sequence
    initial begin
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        err_count = 0; cycle_count = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        cfg = '{current_limit: 15'd2458, voltage_step: 8'd7, settle_ticks: 16'd4000,
                average_count: 8'd100, tick_nanoseconds: 20'd50000, zero_band: 12'd205};
        m_stage = STG_CLEAR; m_drive = 0; m_wait = 0; m_csum = 0;
        m_stepv[0] = 0; m_stepv[1] = 0; m_stepi[0] = 0; m_stepi[1] = 0;
        m_res = 0; m_lsum = 0; m_rep = 0; m_done = 1'b0; m_ind = 0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, zero bus, a full pass with quick settings
        load_settings(100, 255, 1, 1, 1000000, 4095);
        set_idling(0);
        sample_q.push_back({24'h000000, 16'h8000});
        sample_q.push_back({24'hFFFFFF, 16'h7FFF});
        sample_q.push_back({24'hFFFFFF, 16'h0000});
        sample_q.push_back({24'h000000, 16'h0000});
        sample_q.push_back({24'h000000, 16'h7FFF});
        sample_q.push_back({24'h000000, 16'h7FFF});
        sample_q.push_back({24'h000000, 16'h7FFF});
        sample_q.push_back({24'h000000, 16'h7FFF});
        sample_q.push_back({24'h000000, 16'h7FFF});
        sample_q.push_back({24'h000000, 16'h0000});
        sample_q.push_back({24'h000000, 16'h7FFF});
        sample_q.push_back({24'h000000, 16'hFFFF});
        sample_q.push_back({24'h800000, 16'h8000});
        sample_q.push_back({24'h000001, 16'h0001});
        queue_random(200);
        drain();

        // Minimum settings, zero average count acts as one
        load_settings(0, 1, 2, 0, 1, 0);
        set_idling(1);
        queue_random(300);
        drain();

        // Maximum limit and averaging
        load_settings(32767, 128, 3, 255, 50000, 205);
        set_idling(2);
        queue_random(300);
        drain();

        // Longest settle time: never closes in this short phase
        load_settings(2458, 7, 65535, 3, 50000, 205);
        set_idling(3);
        queue_random(40);
        drain();

        // Mid settings, with the sender held off until all results are back
        load_settings(500, 50, 1, 2, 20000, 300);
        set_idling(3);
        queue_random(230);
        while (sample_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
            @(posedge i_clk);
        set_idling(0);
        queue_random(230);
        drain();

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
